// ===== rtl/ctbe_pkg.sv =====
`timescale 1ns / 1ps

package ctbe_pkg;

    localparam int CH_W    = 8;
    localparam int POS_W   = 12;
    localparam int DELTA_W = CH_W + 1;

    // one input word: a color-table sample
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            last_sample;
    } sample_t;

    // one output word: a breakpoint key
    typedef struct packed {
        logic [POS_W-1:0] key_position;
        logic [CH_W-1:0]  left_red;
        logic [CH_W-1:0]  left_green;
        logic [CH_W-1:0]  left_blue;
        logic [CH_W-1:0]  left_alpha;
        logic [CH_W-1:0]  right_red;
        logic [CH_W-1:0]  right_green;
        logic [CH_W-1:0]  right_blue;
        logic [CH_W-1:0]  right_alpha;
        logic             split_key;
        logic             end_of_set;
    } key_t;

    // per-channel slope, current minus previous sample
    typedef logic signed [DELTA_W-1:0] delta_t;

    // which keys the current sample produces
    typedef struct packed {
        logic has_key;
        logic has_end;
    } kg_status_t;

endpackage

// ===== rtl/ctbe_key_gen.sv =====
`timescale 1ns / 1ps

module ctbe_key_gen
    import ctbe_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  sample_t    sample,
    input  logic       take,
    output key_t       key0,
    output key_t       key1,
    output kg_status_t status
);

    localparam int IDX_W = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);
    localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [CH_W-1:0]  prev_reg  [4];
    logic [CH_W-1:0]  prev_next [4];
    delta_t           dlt_reg   [4];
    delta_t           dlt_next  [4];

    logic [CH_W-1:0]        cur [4];
    delta_t                 nd  [4];
    logic                   changed;
    logic                   nonzero;
    logic [POS_W+IDX_W-1:0] pos_ext;
    logic [POS_W-1:0]       pos;
    key_t                   key_a;
    key_t                   key_e;

    assign cur[0] = sample.red;
    assign cur[1] = sample.green;
    assign cur[2] = sample.blue;
    assign cur[3] = sample.alpha;

    assign pos_ext = (POS_W+IDX_W)'(idx_reg);
    assign pos     = pos_ext[POS_W-1:0];

    always_comb
    begin
        changed = 1'b0;
        nonzero = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            nd[c] = delta_t'({1'b0, cur[c]}) - delta_t'({1'b0, prev_reg[c]});
            if (nd[c] != dlt_reg[c])
                changed = 1'b1;
            if (cur[c] != prev_reg[c])
                nonzero = 1'b1;
        end
    end

    // key at this index: start key, split key or plain key
    always_comb
    begin
        key_a = '0;
        key_a.end_of_set = 1'b0;
        if (idx_reg == IDX_ONE)
        begin
            key_a.key_position = '0;
            key_a.left_red    = prev_reg[0];
            key_a.left_green  = prev_reg[1];
            key_a.left_blue   = prev_reg[2];
            key_a.left_alpha  = prev_reg[3];
            key_a.right_red   = prev_reg[0];
            key_a.right_green = prev_reg[1];
            key_a.right_blue  = prev_reg[2];
            key_a.right_alpha = prev_reg[3];
            key_a.split_key   = 1'b0;
        end
        else
        begin
            key_a.key_position = pos;
            key_a.left_red    = nonzero ? prev_reg[0] : cur[0];
            key_a.left_green  = nonzero ? prev_reg[1] : cur[1];
            key_a.left_blue   = nonzero ? prev_reg[2] : cur[2];
            key_a.left_alpha  = nonzero ? prev_reg[3] : cur[3];
            key_a.right_red   = cur[0];
            key_a.right_green = cur[1];
            key_a.right_blue  = cur[2];
            key_a.right_alpha = cur[3];
            key_a.split_key   = nonzero;
        end
    end

    always_comb
    begin
        key_e.key_position = pos;
        key_e.left_red    = cur[0];
        key_e.left_green  = cur[1];
        key_e.left_blue   = cur[2];
        key_e.left_alpha  = cur[3];
        key_e.right_red   = cur[0];
        key_e.right_green = cur[1];
        key_e.right_blue  = cur[2];
        key_e.right_alpha = cur[3];
        key_e.split_key   = 1'b0;
        key_e.end_of_set  = 1'b1;
    end

    always_comb
    begin
        status.has_key = 1'b0;
        status.has_end = 1'b0;
        if (idx_reg != '0)
        begin
            status.has_key = (idx_reg == IDX_ONE) || changed;
            status.has_end = sample.last_sample;
        end
    end

    // end key moves up when it is the only key
    assign key0 = status.has_key ? key_a : key_e;
    assign key1 = key_e;

    always_comb
    begin
        idx_next = idx_reg;
        for (int c = 0; c < 4; c++)
        begin
            prev_next[c] = prev_reg[c];
            dlt_next[c]  = dlt_reg[c];
        end
        if (take)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prev_next[c] = cur[c];
                dlt_next[c]  = (idx_reg == '0) ? '0 : nd[c];
            end
            if (idx_reg == '0)
                idx_next = sample.last_sample ? '0 : IDX_ONE;
            else if (sample.last_sample)
                idx_next = '0;
            else if (idx_reg != IDX_MAX)
                idx_next = idx_reg + IDX_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            for (int c = 0; c < 4; c++)
            begin
                prev_reg[c] <= '0;
                dlt_reg[c]  <= '0;
            end
        end
        else
        begin
            idx_reg <= idx_next;
            for (int c = 0; c < 4; c++)
            begin
                prev_reg[c] <= prev_next[c];
                dlt_reg[c]  <= dlt_next[c];
            end
        end
    end

endmodule

// ===== rtl/ctbe_out_queue.sv =====
`timescale 1ns / 1ps

module ctbe_out_queue
    import ctbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_num,
    input  key_t       push0,
    input  key_t       push1,
    output logic [1:0] free_slots,
    output logic       key_valid,
    input  logic       key_stall,
    output key_t       key
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    key_t       slot0_reg;
    key_t       slot0_next;
    key_t       slot1_reg;
    key_t       slot1_next;

    logic       pop;
    logic [1:0] cnt_left;

    assign pop        = (cnt_reg != 2'd0) && !key_stall;
    assign cnt_left   = cnt_reg - {1'b0, pop};
    assign free_slots = 2'd2 - cnt_left;
    assign key_valid  = (cnt_reg != 2'd0);
    assign key        = slot0_reg;

    always_comb
    begin
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        if (push_num != 2'd0)
        begin
            if (cnt_left == 2'd0)
                slot0_next = push0;
            else
                slot1_next = push0;
        end
        if (push_num == 2'd2)
            slot1_next = push1;
        cnt_next = cnt_left + push_num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ===== rtl/color_table_breakpoint_extractor_top.sv =====
`timescale 1ns / 1ps

// color-table breakpoint extractor
// input channel (sample_valid / sample_stall / sample): one RGBA sample per
//   word, last_sample set on the final sample of a table
// output channel (key_valid / key_stall / key): breakpoint keys in ascending
//   position order, end_of_set set on the end key of each table
// a sample produces zero, one or two keys; a one-sample table produces none
// order: a sample lands in the input register on the edge it is taken; once
//   the two-entry output queue has room for all its keys they are written
//   into it, and key_valid follows from the registered queue count
// throughput: one sample per cycle while samples give at most one key each
//   and key_stall stays low; the queue drains one word per unstalled cycle,
//   so a sample's second key shows as a stall once the queue has filled up
// back pressure: key_stall holds the queue head; the input register waits
//   until the queue has room for all keys of its sample, and while it waits
//   sample_stall is high and the producer holds its word
// reset: clears the sample index, the stored sample and slopes, the input
//   valid flag and the queue count, so the next sample starts a new table
module color_table_breakpoint_extractor_top
    import ctbe_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    output logic    key_valid,
    input  logic    key_stall,
    output key_t    key
);

    // input register
    sample_t    in_reg;
    logic       in_vld_reg;
    logic       in_vld_next;

    logic       accept;
    logic       process;
    logic [1:0] need;
    logic [1:0] push_num;
    logic [1:0] free_slots;
    key_t       key0;
    key_t       key1;
    kg_status_t status;

    assign need     = {1'b0, status.has_key} + {1'b0, status.has_end};
    // keys leave the input register only when the queue can take all of them
    assign process  = in_vld_reg && (need <= free_slots);
    assign push_num = process ? need : 2'd0;

    assign sample_stall = in_vld_reg && !process;
    assign accept       = sample_valid && !sample_stall;
    assign in_vld_next  = accept || (in_vld_reg && !process);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= sample;
    end

    // slope tracking and key building
    ctbe_key_gen #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_key_gen (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (in_reg),
        .take   (process),
        .key0   (key0),
        .key1   (key1),
        .status (status)
    );

    // output queue, also the skid between the two sides
    ctbe_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_num   (push_num),
        .push0      (key0),
        .push1      (key1),
        .free_slots (free_slots),
        .key_valid  (key_valid),
        .key_stall  (key_stall),
        .key        (key)
    );

`ifndef NO_ASSERTIONS
    // a key without a split carries one color on both sides
    assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key.split_key |->
            key.left_red == key.right_red && key.left_green == key.right_green &&
            key.left_blue == key.right_blue && key.left_alpha == key.right_alpha)
    else $error("plain key with differing left and right colors");

    // the end key is never a split key
    assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key.end_of_set |-> !key.split_key)
    else $error("end key marked as split");

    // a held sample is never dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !process |=> in_vld_reg && $stable(in_reg))
    else $error("held sample lost from input register");

    // two keys from one sample always end with the end key
    assert property (@(posedge clk) disable iff (!rst_n)
        process && need == 2'd2 |-> key1.end_of_set && !key0.end_of_set)
    else $error("key pair out of order");
`endif

endmodule

// ===== sim/color_table_breakpoint_extractor_top_tb.sv =====
`timescale 1ns / 1ps

typedef logic [3:0][ctbe_pkg::CH_W-1:0] rgba_t;

// tracks the breakpoint keys a stream of samples should produce
class breakpoint_tracker;
    int unsigned            max_index;
    int unsigned            sample_pos;
    rgba_t                  last_color;
    ctbe_pkg::delta_t       last_slope [4];
    ctbe_pkg::key_t         expected_keys [$];
    int                     errors;

    function new(int unsigned max_samples);
        max_index = max_samples - 1;
        sample_pos = 0;
        last_color = '0;
        for (int c = 0; c < 4; c++)
        begin
            last_slope[c] = '0;
        end
        errors = 0;
    endfunction

    task report(string msg);
        $display("%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    function int pending();
        return expected_keys.size();
    endfunction

    // append one key at the tail of the expected list
    function void queue_key(ctbe_pkg::key_t k);
        expected_keys.insert(expected_keys.size(), k);
    endfunction

    function ctbe_pkg::key_t make_key(int unsigned pos, rgba_t lc, rgba_t rc,
                                      bit split, bit eos);
        ctbe_pkg::key_t k;
        k.key_position = pos[ctbe_pkg::POS_W-1:0];
        k.left_red     = lc[0];
        k.left_green   = lc[1];
        k.left_blue    = lc[2];
        k.left_alpha   = lc[3];
        k.right_red    = rc[0];
        k.right_green  = rc[1];
        k.right_blue   = rc[2];
        k.right_alpha  = rc[3];
        k.split_key    = split;
        k.end_of_set   = eos;
        return k;
    endfunction

    // accepted sample word: advance the table state, queue its keys
    function void take_sample(ctbe_pkg::sample_t s);
        rgba_t            cur;
        ctbe_pkg::delta_t slope [4];
        bit               changed;
        bit               moving;
        cur = {s.alpha, s.blue, s.green, s.red};
        changed = 1'b0;
        moving = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            slope[c] = $signed({1'b0, cur[c]}) - $signed({1'b0, last_color[c]});
            if (slope[c] != last_slope[c])
                changed = 1'b1;
            if (slope[c] != 0)
                moving = 1'b1;
        end
        if (sample_pos == 0)
        begin
            // first sample of a table only gets stored
            last_color = cur;
            for (int c = 0; c < 4; c++)
            begin
                last_slope[c] = '0;
            end
            sample_pos = s.last_sample ? 0 : 1;
            return;
        end
        if (sample_pos == 1)
            queue_key(make_key(0, last_color, last_color, 1'b0, 1'b0));
        else if (changed)
        begin
            if (moving)
                queue_key(make_key(sample_pos, last_color, cur, 1'b1, 1'b0));
            else
                queue_key(make_key(sample_pos, cur, cur, 1'b0, 1'b0));
        end
        if (s.last_sample)
            queue_key(make_key(sample_pos, cur, cur, 1'b0, 1'b1));
        last_color = cur;
        for (int c = 0; c < 4; c++)
        begin
            last_slope[c] = slope[c];
        end
        if (s.last_sample)
            sample_pos = 0;
        else if (sample_pos < max_index)
            sample_pos++;
    endfunction

    task check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // accepted key word: compare with the oldest expected key
    task check_key(ctbe_pkg::key_t k);
        ctbe_pkg::key_t want;
        if (expected_keys.size() == 0)
        begin
            report($sformatf("key at position %0d with none expected", k.key_position));
            return;
        end
        want = expected_keys.pop_front();
        check_field("key_position", k.key_position, want.key_position);
        check_field("left_red", k.left_red, want.left_red);
        check_field("left_green", k.left_green, want.left_green);
        check_field("left_blue", k.left_blue, want.left_blue);
        check_field("left_alpha", k.left_alpha, want.left_alpha);
        check_field("right_red", k.right_red, want.right_red);
        check_field("right_green", k.right_green, want.right_green);
        check_field("right_blue", k.right_blue, want.right_blue);
        check_field("right_alpha", k.right_alpha, want.right_alpha);
        check_field("split_key", k.split_key, want.split_key);
        check_field("end_of_set", k.end_of_set, want.end_of_set);
    endtask
endclass

module color_table_breakpoint_extractor_top_tb;
    import ctbe_pkg::*;

    localparam int MAX_SAMPLES  = 4096;
    localparam int CLK_PERIOD   = 8;
    // margin after the last expected key, for the input register and the output queue
    localparam int DRAIN_CYCLES = 16;
    // slowest run: ~2000 words, at most two keys each, receiver stalled up to 61% of cycles
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 650;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    sample_valid = 1'b0;
    logic    sample_stall;
    sample_t sample = '0;
    logic    key_valid;
    logic    key_stall = 1'b0;
    key_t    key;

    // idle chance in percent per cycle for each side
    int unsigned send_idle_pct = 20;
    int unsigned recv_idle_pct = 61;
    int unsigned samples_sent = 0;
    int unsigned cycle_count = 0;

    breakpoint_tracker tracker;

    color_table_breakpoint_extractor_top #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key          (key)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stall, changed on the falling edge
    initial
    begin
        forever
        begin
            @(negedge clk);
            key_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // every accepted key word goes to the checker
    always @(posedge clk)
    begin
        if (rst_n && key_valid && !key_stall)
            tracker.check_key(key);
    end

    function automatic sample_t mk_sample(int r, int g, int b, int a, bit eot);
        sample_t s;
        s.red         = r[7:0];
        s.green       = g[7:0];
        s.blue        = b[7:0];
        s.alpha       = a[7:0];
        s.last_sample = eot;
        return s;
    endfunction

    // one sample word: optional idle cycles, then hold until taken
    task automatic send_sample(input sample_t s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            sample_valid <= 1'b0;
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (sample_stall);
        tracker.take_sample(s);
        samples_sent++;
    endtask

    // sender goes quiet until the block has delivered every key
    task automatic wait_for_keys();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_slope();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return 0;
        else if (roll < 85)
            return int'($urandom_range(0, 8)) - 4;
        else
            return int'($urandom_range(0, 510)) - 255;
    endfunction

    // piecewise-linear table with random breakpoints and some noise samples
    task automatic send_table(input int unsigned len);
        rgba_t       color;
        int          slope [4];
        int unsigned roll;
        sample_t     s;
        color = $urandom;
        for (int c = 0; c < 4; c++)
        begin
            slope[c] = pick_slope();
        end
        for (int unsigned i = 0; i < len; i++)
        begin
            if (i > 0)
            begin
                roll = $urandom_range(0, 99);
                for (int c = 0; c < 4; c++)
                begin
                    // flat stretch, full slope change, or individual channels bend
                    if (roll < 6)
                        slope[c] = 0;
                    else if (roll < 12 || $urandom_range(0, 99) < 10)
                        slope[c] = pick_slope();
                    color[c] = color[c] + slope[c][7:0];
                end
            end
            if ($urandom_range(0, 99) < 8)
                color = $urandom;
            s = {color[0], color[1], color[2], color[3], (i == len - 1)};
            send_sample(s);
        end
    endtask

    task automatic random_tables(input int unsigned count);
        int unsigned goal;
        int unsigned roll;
        int unsigned len;
        goal = samples_sent + count;
        while (samples_sent < goal)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                len = 1;
            else if (roll < 20)
                len = 2;
            else if (roll < 80)
                len = $urandom_range(3, 20);
            else
                len = $urandom_range(21, 80);
            send_table(len);
        end
    endtask

    initial
    begin
        tracker = new(MAX_SAMPLES);
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // one-sample tables, nothing comes out
        send_sample(mk_sample(0, 0, 0, 0, 1'b1));
        send_sample(mk_sample(255, 255, 255, 255, 1'b1));
        // two samples: start key and end key
        send_sample(mk_sample(0, 0, 0, 0, 1'b0));
        send_sample(mk_sample(255, 255, 255, 255, 1'b1));
        // constant slope, no key in between
        send_sample(mk_sample(0, 0, 0, 0, 1'b0));
        send_sample(mk_sample(10, 20, 30, 40, 1'b0));
        send_sample(mk_sample(20, 40, 60, 80, 1'b1));
        // slope drops to zero, plain key
        send_sample(mk_sample(5, 5, 5, 5, 1'b0));
        send_sample(mk_sample(6, 6, 6, 6, 1'b0));
        send_sample(mk_sample(6, 6, 6, 6, 1'b0));
        send_sample(mk_sample(6, 6, 6, 6, 1'b1));
        // full-range swings, a split key, plain key together with the end key
        send_sample(mk_sample(255, 0, 255, 0, 1'b0));
        send_sample(mk_sample(0, 255, 0, 255, 1'b0));
        send_sample(mk_sample(255, 0, 255, 0, 1'b0));
        send_sample(mk_sample(255, 0, 255, 0, 1'b1));
        // one channel bends alone
        send_sample(mk_sample(0, 0, 0, 0, 1'b0));
        send_sample(mk_sample(0, 0, 0, 0, 1'b0));
        send_sample(mk_sample(0, 0, 0, 1, 1'b0));
        send_sample(mk_sample(0, 0, 0, 2, 1'b0));
        send_sample(mk_sample(0, 0, 0, 2, 1'b1));
        wait_for_keys();

        random_tables(PHASE_ITEMS);

        send_idle_pct = 61;
        recv_idle_pct = 20;
        random_tables(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_tables(PHASE_ITEMS);

        wait_for_keys();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
